// ----- rtl/core/tkb_pkg.sv -----
// ----------------------------------------------------------------------------
// tkb_pkg
// Shared types and constants for the TCP keepalive batcher.
// ----------------------------------------------------------------------------
`default_nettype none
package tkb_pkg;

  localparam int QUEUE_DEPTH_DEF = 20;
  localparam int HANDLE_BITS_DEF = 16;

  // Event codes carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_OUT_PKT  = 2'd0,
    FUNC_IN_PKT   = 2'd1,
    FUNC_FLUSH    = 2'd2,
    FUNC_RELEASE  = 2'd3
  } func_t;

  // Register indexes on the configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL = 2'd1;
  localparam int CFG_DATA_BITS = 8;

  // Result kinds carried in the output tuser
  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [7:0] MAX_INTERVAL = 8'd180;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [3:0] IPV6_VERSION = 4'd6;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/tkb_cell.sv -----
// ----------------------------------------------------------------------------
// tkb_cell
// One slot of the handle queue: loads a new handle or takes its neighbour's.
// ----------------------------------------------------------------------------
`default_nettype none
module tkb_cell #(
  parameter int HANDLE_BITS = tkb_pkg::HANDLE_BITS_DEF
) (
  input  wire                          clk,
  input  wire tkb_pkg::cell_ctrl_t     ctrl,
  input  wire logic [HANDLE_BITS-1:0]  load_data,
  input  wire logic [HANDLE_BITS-1:0]  next_data,
  output logic      [HANDLE_BITS-1:0]  data
);
  import tkb_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= next_data;
    end else if (ctrl.load) begin
      data <= load_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tkb_classify.sv -----
// ----------------------------------------------------------------------------
// tkb_classify
// Decides whether a registered packet header describes a TCP keepalive.
// ----------------------------------------------------------------------------
`default_nettype none
module tkb_classify (
  input  wire logic [3:0]  ip_version,
  input  wire logic [15:0] ip_length,
  input  wire logic [3:0]  ipv4_header_words,
  input  wire logic [7:0]  ip_protocol,
  input  wire logic [3:0]  tcp_header_words,
  input  wire logic [3:0]  tcp_flags,
  input  wire logic [31:0] tcp_seq,
  input  wire logic [31:0] send_next,
  output logic             keepalive
);
  import tkb_pkg::*;

  logic [5:0]  ip_hdr_bytes;
  logic [5:0]  tcp_hdr_bytes;
  logic [6:0]  hdr_bytes;
  logic [15:0] payload;
  logic        ver_ok;
  logic        len_ok;
  logic        flags_ok;
  logic        seq_ok;

  always_comb begin
    ver_ok        = (ip_version == IPV4_VERSION) || (ip_version == IPV6_VERSION);
    // IPv6 payload length already excludes its fixed header
    ip_hdr_bytes  = (ip_version == IPV6_VERSION) ? 6'd0 : {ipv4_header_words, 2'b00};
    tcp_hdr_bytes = {tcp_header_words, 2'b00};
    hdr_bytes     = {1'b0, ip_hdr_bytes} + {1'b0, tcp_hdr_bytes};
    payload       = ip_length - 16'(hdr_bytes);
    len_ok        = (ip_length >= 16'(hdr_bytes)) && (payload <= 16'd1);
    flags_ok      = (tcp_flags == 4'b0001);
    seq_ok        = (tcp_seq == (send_next - 32'd1));
    keepalive     = ver_ok && (ip_protocol == PROTO_TCP) && len_ok && flags_ok && seq_ok;
  end

endmodule
`default_nettype wire

// ----- rtl/core/tcp_keepalive_batcher_top.sv -----
// ----------------------------------------------------------------------------
// tcp_keepalive_batcher_top
// Holds outgoing TCP keepalive handles in a row of shift cells and releases
// them all, oldest first, on other traffic while enabled or on flush/release.
// ----------------------------------------------------------------------------
// Order: once an input item is accepted the decide state runs; when a release
//   runs, the drain state then presents every held handle (0..QUEUE_DEPTH),
//   and the status item comes last. No new input item is accepted until the
//   status item is loaded into the output register. The cell row drains one
//   handle per cycle through the output register while the output is not stalled.
// Reset: synchronous; empties the queue, clears the last wake time and enable,
//   and sets the wake interval to 180 s. Queue cells are not cleared.
`default_nettype none
module tcp_keepalive_batcher_top #(
  parameter int QUEUE_DEPTH = tkb_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = tkb_pkg::HANDLE_BITS_DEF,
  localparam int IN_BITS    = ((136 + HANDLE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = ((HANDLE_BITS + 2 + 7) / 8) * 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // config write channel
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tkb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tkb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input stream
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // s_tdata, low bit up: now_seconds, packet_handle, ip_version, ip_length,
  //   ipv4_header_words, ip_protocol, tcp_header_words, tcp_flags, tcp_seq,
  //   send_next, zero pad
  input  wire logic [IN_BITS-1:0]               s_tdata,
  input  wire logic [1:0]                       s_tuser,  // func
  // output stream
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // m_tdata, low bit up: out_handle, held, wake_daemon, zero pad
  output logic      [OUT_BITS-1:0]              m_tdata,
  output logic                                  m_tuser,  // kind
  output logic                                  m_tlast   // last
);
  import tkb_pkg::*;

  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int HB      = HANDLE_BITS;
  localparam int O_NOW   = 0;
  localparam int O_HDL   = 32;
  localparam int O_VER   = O_HDL + HB;
  localparam int O_LEN   = O_VER + 4;
  localparam int O_V4W   = O_LEN + 16;
  localparam int O_PROTO = O_V4W + 4;
  localparam int O_TCPW  = O_PROTO + 8;
  localparam int O_FLAGS = O_TCPW + 4;
  localparam int O_SEQ   = O_FLAGS + 4;
  localparam int O_NXT   = O_SEQ + 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DRAIN,
    ST_STATUS
  } state_t;

  state_t             state;
  func_t              func_r;
  logic [IN_BITS-1:0] item_r;
  logic [CW-1:0]      held_count;
  logic [31:0]        last_wake_time;
  logic               enable;
  logic [7:0]         notify_interval;
  logic               held_r;
  logic               wake_r;

  logic [HB-1:0]      item_handle;
  logic [31:0]        item_now;
  logic               keepalive;
  logic               queue_it;
  logic               wake_hit;
  logic [32:0]        wake_limit;
  logic               out_free;
  logic               out_load;
  logic               load_en;
  logic               shift_en;
  logic [HB-1:0]      status_handle;

  cell_ctrl_t         cell_ctrl [QUEUE_DEPTH];
  logic [HB-1:0]      cell_data [QUEUE_DEPTH];

  assign cfg_ready   = 1'b1;
  assign s_tready    = (state == ST_IDLE);
  assign item_handle = item_r[O_HDL +: HB];
  assign item_now    = item_r[O_NOW +: 32];

  tkb_classify u_classify (
    .ip_version        (item_r[O_VER +: 4]),
    .ip_length         (item_r[O_LEN +: 16]),
    .ipv4_header_words (item_r[O_V4W +: 4]),
    .ip_protocol       (item_r[O_PROTO +: 8]),
    .tcp_header_words  (item_r[O_TCPW +: 4]),
    .tcp_flags         (item_r[O_FLAGS +: 4]),
    .tcp_seq           (item_r[O_SEQ +: 32]),
    .send_next         (item_r[O_NXT +: 32]),
    .keepalive         (keepalive)
  );

  always_comb begin
    out_free   = !m_tvalid || m_tready;
    queue_it   = (func_r == FUNC_OUT_PKT) && enable && keepalive &&
                 (held_count < CW'(QUEUE_DEPTH));
    wake_limit = {1'b0, last_wake_time} + 33'(notify_interval);
    wake_hit   = {1'b0, item_now} > wake_limit;
    load_en    = (state == ST_DECIDE) && queue_it;
    shift_en   = (state == ST_DRAIN) && (held_count != '0) && out_free;
    out_load   = shift_en || ((state == ST_STATUS) && out_free);
    status_handle = ((func_r == FUNC_OUT_PKT) || (func_r == FUNC_IN_PKT)) ?
                    item_handle : '0;
  end

  // Row of queue cells; cell 0 is the oldest handle
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [HB-1:0] nbr;
    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nbr = cell_data[i+1];
    end else begin : g_end
      assign nbr = '0;
    end
    assign cell_ctrl[i].load  = load_en && (held_count == CW'(i));
    assign cell_ctrl[i].shift = shift_en;
    tkb_cell #(.HANDLE_BITS(HB)) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .load_data (item_handle),
      .next_data (nbr),
      .data      (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      held_count      <= '0;
      last_wake_time  <= '0;
      enable          <= 1'b0;
      notify_interval <= MAX_INTERVAL;
      m_tvalid        <= 1'b0;
    end else begin
      // hold a waiting item, present a new one when the register is free
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ENABLE) begin
          enable <= cfg_data[0];
        end else if (cfg_index == CFG_INTERVAL && cfg_data != '0) begin
          notify_interval <= (cfg_data > MAX_INTERVAL) ? MAX_INTERVAL : cfg_data;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item_r <= s_tdata;
            func_r <= func_t'(s_tuser);
            state  <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          held_r <= queue_it;
          wake_r <= ((func_r == FUNC_OUT_PKT) || (func_r == FUNC_IN_PKT)) &&
                    enable && !queue_it && wake_hit;
          unique case (func_r)
            FUNC_OUT_PKT, FUNC_IN_PKT: begin
              if (!enable) begin
                state <= ST_STATUS;
              end else if (queue_it) begin
                held_count <= held_count + CW'(1);
                state      <= ST_STATUS;
              end else begin
                if (wake_hit) begin
                  last_wake_time <= item_now;
                end
                state <= ST_DRAIN;
              end
            end
            FUNC_FLUSH: begin
              state <= ST_DRAIN;
            end
            FUNC_RELEASE: begin
              // detach: overrides any enable write in the same cycle
              last_wake_time <= '0;
              enable         <= 1'b0;
              state          <= ST_DRAIN;
            end
            default: state <= ST_DRAIN;
          endcase
        end
        ST_DRAIN: begin
          if (held_count == '0) begin
            state <= ST_STATUS;
          end else if (out_free) begin
            m_tuser    <= KIND_RELEASE;
            m_tlast    <= 1'b0;
            m_tdata    <= OUT_BITS'({2'b00, cell_data[0]});
            held_count <= held_count - CW'(1);
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            m_tuser  <= KIND_STATUS;
            m_tlast  <= 1'b1;
            m_tdata  <= OUT_BITS'({wake_r, held_r, status_handle});
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && held_count == '0) |=> (state == ST_STATUS))
    else $error("empty drain did not move to status");

  a_release_detach: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && func_r == FUNC_RELEASE) |=> (!enable && last_wake_time == '0))
    else $error("release flush left daemon attached");

  a_release_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_RELEASE) |-> !m_tlast)
    else $error("released handle marked last");
`endif

endmodule
`default_nettype wire
